FILE: sv/abr_pkg.sv
// Shared types, constants and helpers for the ambient backlight ramp unit.
`timescale 1ns / 1ps
`default_nettype none
package abr_pkg;

	localparam int ABR_SAMPLE_BITS = 10;
	localparam int THR_W    = 10;
	localparam int LVL_W    = 8;
	localparam int CNT_W    = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;
	localparam int QUO_W    = 8;

	localparam logic [LVL_W-1:0] FULL_SCALE = 8'd255;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NIGHT_THR     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAY_THR       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NIGHT_LEVEL   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAY_LEVEL     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LEVEL = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY      = 4'd7;

	// Reset values of the configuration registers.
	localparam logic [THR_W-1:0] RST_NIGHT_THR     = 10'd100;
	localparam logic [THR_W-1:0] RST_DAY_THR       = 10'd800;
	localparam logic [LVL_W-1:0] RST_NIGHT_LEVEL   = 8'd20;
	localparam logic [LVL_W-1:0] RST_DAY_LEVEL     = 8'd255;
	localparam logic [LVL_W-1:0] RST_DEFAULT_LEVEL = 8'd128;
	localparam logic [CNT_W-1:0] RST_RAMP_PERIOD   = 16'd15;
	localparam logic [CNT_W-1:0] RST_SAMPLE_PERIOD = 16'd200;
	localparam logic             RST_POLARITY      = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} abr_state_t;

	typedef struct packed {
		logic start;
		logic mul;
		logic div_step;
		logic finish;
	} abr_cmd_t;

	typedef struct packed {
		logic need_div;
	} abr_stat_t;

	function automatic logic [LVL_W-1:0] duty_of(input logic [LVL_W-1:0] lvl,
		input logic inverted);
		duty_of = inverted ? FULL_SCALE - lvl : lvl;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

endpackage
`default_nettype wire

FILE: sv/ambient_backlight_ramp_unit.sv
// Top level of the ambient backlight ramp unit: controller plus datapath.
// The result is registered in ST_FIN, entered straight from idle when the target comes
// from a threshold, or after ST_MUL and ST_DIV when the linear map runs (a multiply state,
// a restoring divider with one quotient bit per cycle, a result load state).
// Flow: in_stall holds off new requests until ST_FIN loads the result and goes idle.
// Reset: asynchronous, active low; configuration and brightness state reset at once.
`timescale 1ns / 1ps
`default_nettype none
module ambient_backlight_ramp_unit
	import abr_pkg::*;
#(
	parameter int SAMPLE_BITS = ABR_SAMPLE_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DAT_W-1:0]   cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   backlight_on,
	input  wire logic [SAMPLE_BITS-1:0] light_sample,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [LVL_W-1:0]            pwm_duty,
	output logic                        pwm_update,
	output logic [LVL_W-1:0]            current_level,
	output logic [LVL_W-1:0]            target_level,
	output logic                        sample_taken
);

	abr_cmd_t  cmd;
	abr_stat_t stat;

	assign cfg_ready = 1'b1;

	abr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	abr_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.backlight_on  (backlight_on),
		.light_sample  (light_sample),
		.cmd           (cmd),
		.stat          (stat),
		.pwm_duty      (pwm_duty),
		.pwm_update    (pwm_update),
		.current_level (current_level),
		.target_level  (target_level),
		.sample_taken  (sample_taken)
	);

endmodule
`default_nettype wire

FILE: sv/abr_ctrl.sv
// Sequencing controller: accepts a tick, runs the map division when needed, loads the result.
`timescale 1ns / 1ps
`default_nettype none
module abr_ctrl
	import abr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire abr_stat_t stat,
	output abr_cmd_t       cmd
);

	abr_state_t state_q, state_nxt;
	logic [2:0] iter_q;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == ST_IDLE);
	// The output register can take a new result if empty or being drained now.
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = stat.need_div ? ST_MUL : ST_FIN;
				end
			end
			ST_MUL: state_nxt = ST_DIV;
			ST_DIV: begin
				if (iter_q == 3'd7) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.start    = accept;
			ST_MUL:  cmd.mul      = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_FIN:  cmd.finish   = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				iter_q <= iter_q + 3'd1;
			end else begin
				iter_q <= '0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/abr_dpath.sv
// Datapath: configuration registers, brightness state, target map with serial divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module abr_dpath
	import abr_pkg::*;
#(
	parameter int SAMPLE_BITS = ABR_SAMPLE_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DAT_W-1:0]   cfg_data,
	input  wire logic                   backlight_on,
	input  wire logic [SAMPLE_BITS-1:0] light_sample,
	input  wire abr_cmd_t               cmd,
	output abr_stat_t                   stat,
	output logic [LVL_W-1:0]            pwm_duty,
	output logic                        pwm_update,
	output logic [LVL_W-1:0]            current_level,
	output logic [LVL_W-1:0]            target_level,
	output logic                        sample_taken
);

	localparam int RW = SAMPLE_BITS + QUO_W;

	// Configuration registers.
	logic [THR_W-1:0] night_thr_q, day_thr_q;
	logic [LVL_W-1:0] night_lvl_q, day_lvl_q;
	logic [CNT_W-1:0] ramp_period_q, sample_period_q;
	logic             polarity_q;

	// Brightness state.
	logic [LVL_W-1:0] level_now_q, level_goal_q, duty_held_q;
	logic [CNT_W-1:0] ramp_elapsed_q, sample_elapsed_q;
	logic             stepped_q, sampled_q, map_q;

	// Map operands and divider.
	logic [SAMPLE_BITS-1:0] dx_q, span_q;
	logic [QUO_W-1:0]       mag_q, quo_q;
	logic                   neg_q;
	logic [RW-1:0]          rem_q, dvs_q;

	logic [THR_W+SAMPLE_BITS-1:0] night_ext, day_ext;
	logic [SAMPLE_BITS-1:0]       thr_n, thr_d;
	logic                         below, above, thr_eq;
	logic [CNT_W-1:0]             ramp_inc, sample_inc;
	logic                         do_step, do_sample;
	logic [LVL_W-1:0]             level_step;
	logic [LVL_W-1:0]             goal_direct, goal_final;
	logic                         rem_ge;

	// Thresholds are cut or widened to the sample width.
	assign night_ext = {{SAMPLE_BITS{1'b0}}, night_thr_q};
	assign day_ext   = {{SAMPLE_BITS{1'b0}}, day_thr_q};
	assign thr_n     = night_ext[SAMPLE_BITS-1:0];
	assign thr_d     = day_ext[SAMPLE_BITS-1:0];

	assign below  = light_sample < thr_n;
	assign above  = light_sample > thr_d;
	assign thr_eq = thr_n == thr_d;

	assign ramp_inc   = sat_inc(ramp_elapsed_q);
	assign sample_inc = sat_inc(sample_elapsed_q);
	assign do_step    = backlight_on && (level_goal_q != level_now_q)
		&& (ramp_inc > ramp_period_q);
	assign do_sample  = backlight_on && (sample_inc > sample_period_q);
	assign level_step = (level_goal_q > level_now_q) ? level_now_q + 8'd1
		: level_now_q - 8'd1;

	assign goal_direct   = (!below && above) ? day_lvl_q : night_lvl_q;
	assign stat.need_div = do_sample && !below && !above && !thr_eq;

	assign rem_ge     = rem_q >= dvs_q;
	assign goal_final = map_q ? (neg_q ? night_lvl_q - quo_q : night_lvl_q + quo_q)
		: level_goal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			night_thr_q     <= RST_NIGHT_THR;
			day_thr_q       <= RST_DAY_THR;
			night_lvl_q     <= RST_NIGHT_LEVEL;
			day_lvl_q       <= RST_DAY_LEVEL;
			ramp_period_q   <= RST_RAMP_PERIOD;
			sample_period_q <= RST_SAMPLE_PERIOD;
			polarity_q      <= RST_POLARITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NIGHT_THR:     night_thr_q     <= cfg_data[THR_W-1:0];
				REG_DAY_THR:       day_thr_q       <= cfg_data[THR_W-1:0];
				REG_NIGHT_LEVEL:   night_lvl_q     <= cfg_data[LVL_W-1:0];
				REG_DAY_LEVEL:     day_lvl_q       <= cfg_data[LVL_W-1:0];
				// The reset level is fixed; a write here never reaches the state.
				REG_DEFAULT_LEVEL: ;
				REG_RAMP_PERIOD:   ramp_period_q   <= cfg_data[CNT_W-1:0];
				REG_SAMPLE_PERIOD: sample_period_q <= cfg_data[CNT_W-1:0];
				REG_POLARITY:      polarity_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_now_q      <= RST_DEFAULT_LEVEL;
			level_goal_q     <= RST_DEFAULT_LEVEL;
			duty_held_q      <= duty_of(RST_DEFAULT_LEVEL, RST_POLARITY);
			ramp_elapsed_q   <= '0;
			sample_elapsed_q <= '0;
			stepped_q        <= 1'b0;
			sampled_q        <= 1'b0;
			map_q            <= 1'b0;
		end else begin
			if (cmd.start) begin
				ramp_elapsed_q   <= do_step ? '0 : ramp_inc;
				sample_elapsed_q <= do_sample ? '0 : sample_inc;
				stepped_q        <= do_step;
				sampled_q        <= do_sample;
				map_q            <= stat.need_div;
				if (do_step) begin
					level_now_q <= level_step;
					duty_held_q <= duty_of(level_step, polarity_q);
				end
				// The step above uses the old target; the new one lands afterward.
				if (do_sample && !stat.need_div) begin
					level_goal_q <= goal_direct;
				end
			end
			if (cmd.finish) begin
				level_goal_q <= goal_final;
			end
		end
	end

	// Linear map: (x - n) * |day - night| / (d - n), one quotient bit a cycle.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dx_q   <= light_sample - thr_n;
			span_q <= thr_d - thr_n;
			neg_q  <= day_lvl_q < night_lvl_q;
			mag_q  <= (day_lvl_q < night_lvl_q) ? night_lvl_q - day_lvl_q
				: day_lvl_q - night_lvl_q;
		end
		if (cmd.mul) begin
			rem_q <= RW'(dx_q) * RW'(mag_q);
			dvs_q <= RW'(span_q) << (QUO_W - 1);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dvs_q;
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
		end
		if (cmd.finish) begin
			pwm_duty      <= duty_held_q;
			pwm_update    <= stepped_q;
			current_level <= level_now_q;
			target_level  <= goal_final;
			sample_taken  <= sampled_q;
		end
	end

endmodule
`default_nettype wire

FILE: test/tb_ambient_backlight_ramp_unit.sv
// Self-checking testbench for the ambient backlight ramp unit.
`timescale 1ns / 1ps
module tb_ambient_backlight_ramp_unit;
	import abr_pkg::*;

	localparam int LIGHT_W          = ABR_SAMPLE_BITS;
	localparam int LIGHT_MAX        = (1 << LIGHT_W) - 1;
	localparam int SETTLE_CYCLES    = 16;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int PRINT_LIMIT      = 100;
	localparam int RANDOM_PHASES    = 8;
	localparam int PHASE_TICKS      = 140;
	localparam int SATURATION_TICKS = 40;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = REG_POLARITY + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNMAPPED  = {CFG_IDX_W{1'b1}};

	typedef struct packed {
		logic [LVL_W-1:0] duty;
		logic             update;
		logic [LVL_W-1:0] level;
		logic [LVL_W-1:0] goal;
		logic             sampled;
	} tick_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 backlight_on = 1'b0;
	logic [LIGHT_W-1:0]   light_sample = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [LVL_W-1:0]     pwm_duty;
	logic                 pwm_update;
	logic [LVL_W-1:0]     current_level;
	logic [LVL_W-1:0]     target_level;
	logic                 sample_taken;

	// Shadow copy of the configuration registers.
	logic [THR_W-1:0] cfg_night_thr;
	logic [THR_W-1:0] cfg_day_thr;
	logic [LVL_W-1:0] cfg_night_lvl;
	logic [LVL_W-1:0] cfg_day_lvl;
	logic [LVL_W-1:0] cfg_default_lvl;
	logic [CNT_W-1:0] cfg_ramp_period;
	logic [CNT_W-1:0] cfg_sample_period;
	logic             cfg_inverted;

	// Predicted internal state of the block.
	logic [LVL_W-1:0] level_now;
	logic [LVL_W-1:0] level_goal;
	logic [CNT_W-1:0] ramp_elapsed;
	logic [CNT_W-1:0] sample_elapsed;
	logic [LVL_W-1:0] duty_held;

	tick_result_t awaited_results[$];
	int error_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int hold_asked = 0;
	int hold_granted = 0;
	logic calm = 1'b0;

	ambient_backlight_ramp_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.backlight_on (backlight_on),
		.light_sample (light_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pwm_duty     (pwm_duty),
		.pwm_update   (pwm_update),
		.current_level(current_level),
		.target_level (target_level),
		.sample_taken (sample_taken)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [LVL_W-1:0] map_light_to_level(input logic [LIGHT_W-1:0] x);
		int num;
		int span;
		if (x < cfg_night_thr)
			return cfg_night_lvl;
		if (x > cfg_day_thr)
			return cfg_day_lvl;
		if (cfg_day_thr == cfg_night_thr)
			return cfg_night_lvl;
		num = (int'(x) - int'(cfg_night_thr)) * (int'(cfg_day_lvl) - int'(cfg_night_lvl));
		span = int'(cfg_day_thr) - int'(cfg_night_thr);
		// Signed division truncates toward zero, also when the map falls.
		return LVL_W'(num / span + int'(cfg_night_lvl));
	endfunction

	task automatic advance_backlight(input logic on, input logic [LIGHT_W-1:0] light,
		output tick_result_t res);
		res = '0;
		ramp_elapsed = (ramp_elapsed == {CNT_W{1'b1}}) ? ramp_elapsed : ramp_elapsed + 1'b1;
		sample_elapsed = (sample_elapsed == {CNT_W{1'b1}}) ? sample_elapsed
			: sample_elapsed + 1'b1;
		if (on) begin
			// The step uses the target from before this tick.
			if (level_goal != level_now && ramp_elapsed > cfg_ramp_period) begin
				ramp_elapsed = '0;
				level_now = (level_goal > level_now) ? level_now + 1'b1 : level_now - 1'b1;
				duty_held = cfg_inverted ? FULL_SCALE - level_now : level_now;
				res.update = 1'b1;
			end
			if (sample_elapsed > cfg_sample_period) begin
				sample_elapsed = '0;
				level_goal = map_light_to_level(light);
				res.sampled = 1'b1;
			end
		end
		res.duty = duty_held;
		res.level = level_now;
		res.goal = level_goal;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		// Output is capped so that a badly broken block cannot flood the log.
		if (error_count < PRINT_LIMIT)
			$display("%0t ns: result %0d, %s: got %0d, want %0d", $time, results_seen, what,
				got, want);
		error_count++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_NIGHT_THR:     cfg_night_thr = data[THR_W-1:0];
			REG_DAY_THR:       cfg_day_thr = data[THR_W-1:0];
			REG_NIGHT_LEVEL:   cfg_night_lvl = data[LVL_W-1:0];
			REG_DAY_LEVEL:     cfg_day_lvl = data[LVL_W-1:0];
			REG_DEFAULT_LEVEL: cfg_default_lvl = data[LVL_W-1:0];
			REG_RAMP_PERIOD:   cfg_ramp_period = data;
			REG_SAMPLE_PERIOD: cfg_sample_period = data;
			REG_POLARITY:      cfg_inverted = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_tick(input logic on, input logic [LIGHT_W-1:0] light);
		int gap;
		tick_result_t want;
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		backlight_on <= on;
		light_sample <= light;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_backlight(on, light, want);
		awaited_results.push_back(want);
		// The request is taken, so nothing stays offered behind it.
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Stops offering requests and waits until the block has nothing left in flight.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	function automatic logic [LIGHT_W-1:0] pick_light();
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = LIGHT_MAX;
			2: v = int'(cfg_night_thr) + $urandom_range(0, 4) - 2;
			3: v = int'(cfg_day_thr) + $urandom_range(0, 4) - 2;
			default: v = $urandom_range(0, LIGHT_MAX);
		endcase
		if (v < 0)
			v = 0;
		if (v > LIGHT_MAX)
			v = LIGHT_MAX;
		return LIGHT_W'(v);
	endfunction

	function automatic int pick_value(input int hi);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return hi;
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_period();
		case ($urandom_range(0, 15))
			0: return {CNT_W{1'b1}};
			1: return {CNT_W{1'b1}} - 1'b1;
			2: return CNT_W'($urandom_range(0, 40));
			default: return CNT_W'($urandom_range(0, 5));
		endcase
	endfunction

	task automatic program_random_setup();
		logic [CFG_DAT_W-1:0] night;
		logic [CFG_DAT_W-1:0] day;
		night = CFG_DAT_W'(pick_value(LIGHT_MAX));
		day = ($urandom_range(0, 5) == 0) ? night : CFG_DAT_W'(pick_value(LIGHT_MAX));
		// Upper data bits are junk that the register must drop.
		night[CFG_DAT_W-1:THR_W] = (CFG_DAT_W-THR_W)'($urandom);
		day[CFG_DAT_W-1:THR_W] = (CFG_DAT_W-THR_W)'($urandom);
		write_register(REG_NIGHT_THR, night);
		write_register(REG_DAY_THR, day);
		write_register(REG_NIGHT_LEVEL, CFG_DAT_W'(pick_value(255)));
		write_register(REG_DAY_LEVEL, CFG_DAT_W'(pick_value(255)));
		write_register(REG_DEFAULT_LEVEL, CFG_DAT_W'($urandom));
		write_register(REG_RAMP_PERIOD, pick_period());
		write_register(REG_SAMPLE_PERIOD, pick_period());
		write_register(REG_POLARITY, CFG_DAT_W'($urandom));
	endtask

	task automatic test_reset_state();
		send_tick(1'b0, '0);
		send_tick(1'b0, LIGHT_W'(LIGHT_MAX));
		send_tick(1'b1, '0);
		send_tick(1'b1, LIGHT_W'(LIGHT_MAX));
		wait_for_drain();
	endtask

	task automatic test_threshold_regions();
		write_register(REG_RAMP_PERIOD, '0);
		write_register(REG_SAMPLE_PERIOD, '0);
		write_register(REG_NIGHT_THR, 16'd100);
		write_register(REG_DAY_THR, 16'd800);
		write_register(REG_NIGHT_LEVEL, 16'd20);
		write_register(REG_DAY_LEVEL, 16'd255);
		send_tick(1'b1, 10'd0);
		send_tick(1'b1, 10'd99);
		send_tick(1'b1, 10'd100);
		send_tick(1'b1, 10'd101);
		send_tick(1'b1, 10'd450);
		send_tick(1'b1, 10'd799);
		send_tick(1'b1, 10'd800);
		send_tick(1'b1, 10'd801);
		send_tick(1'b1, 10'd1023);
		wait_for_drain();
	endtask

	task automatic test_falling_map();
		write_register(REG_NIGHT_LEVEL, 16'd250);
		write_register(REG_DAY_LEVEL, 16'd10);
		send_tick(1'b1, 10'd333);
		send_tick(1'b1, 10'd517);
		send_tick(1'b1, 10'd799);
		wait_for_drain();
	endtask

	task automatic test_equal_thresholds();
		write_register(REG_NIGHT_THR, 16'd512);
		write_register(REG_DAY_THR, 16'd512);
		send_tick(1'b1, 10'd511);
		send_tick(1'b1, 10'd512);
		send_tick(1'b1, 10'd513);
		wait_for_drain();
	endtask

	task automatic test_crossed_thresholds();
		write_register(REG_NIGHT_THR, 16'd700);
		write_register(REG_DAY_THR, 16'd300);
		send_tick(1'b1, 10'd500);
		send_tick(1'b1, 10'd299);
		send_tick(1'b1, 10'd701);
		wait_for_drain();
	endtask

	task automatic test_polarity_and_unmapped_writes();
		write_register(REG_POLARITY, 16'd1);
		write_register(REG_DEFAULT_LEVEL, 16'd0);
		write_register(REG_FIRST_UNMAPPED, 16'hFFFF);
		write_register(REG_LAST_UNMAPPED, 16'hFFFF);
		send_tick(1'b1, 10'd0);
		send_tick(1'b1, 10'd1023);
		wait_for_drain();
	endtask

	task automatic test_disabled_hold();
		send_tick(1'b0, 10'd0);
		send_tick(1'b0, 10'd1023);
		send_tick(1'b0, 10'd512);
		send_tick(1'b1, 10'd512);
		wait_for_drain();
	endtask

	// Top-of-range periods are not exceeded here, so neither fires; a short ramp period follows.
	task automatic test_counter_saturation();
		logic saved_calm;
		saved_calm = calm;
		calm = 1'b1;
		write_register(REG_NIGHT_THR, 16'd0);
		write_register(REG_DAY_THR, 16'd1023);
		write_register(REG_RAMP_PERIOD, 16'hFFFF);
		write_register(REG_SAMPLE_PERIOD, 16'hFFFE);
		for (int i = 0; i < SATURATION_TICKS; i++)
			send_tick($urandom_range(0, 3) == 0, LIGHT_W'($urandom));
		wait_for_drain();
		write_register(REG_RAMP_PERIOD, 16'd3);
		for (int i = 0; i < 6; i++)
			send_tick(1'b1, LIGHT_W'($urandom));
		wait_for_drain();
		calm = saved_calm;
	endtask

	task automatic test_output_backpressure();
		write_register(REG_RAMP_PERIOD, 16'd0);
		write_register(REG_SAMPLE_PERIOD, 16'd1);
		hold_asked++;
		for (int i = 0; i < 40; i++)
			send_tick(1'b1, pick_light());
		wait_for_drain();
	endtask

	task automatic test_sender_pause();
		for (int i = 0; i < 15; i++)
			send_tick(1'b1, pick_light());
		// Hold new requests back until every result is out.
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 15; i++)
			send_tick(1'b1, pick_light());
		wait_for_drain();
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES - 1)
				calm = 1'b1;
			program_random_setup();
			for (int i = 0; i < PHASE_TICKS; i++)
				send_tick($urandom_range(0, 7) != 0, pick_light());
			wait_for_drain();
		end
	endtask

	always @(negedge clk) begin
		if (hold_asked != hold_granted) begin
			hold_granted = hold_asked;
			stall_left = HOLD_OFF_CYCLES;
		end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 15);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with no request pending", pwm_duty, -1);
			end else begin
				want = awaited_results.pop_front();
				if (pwm_duty !== want.duty)
					report_mismatch("pwm_duty", pwm_duty, want.duty);
				if (pwm_update !== want.update)
					report_mismatch("pwm_update", pwm_update, want.update);
				if (current_level !== want.level)
					report_mismatch("current_level", current_level, want.level);
				if (target_level !== want.goal)
					report_mismatch("target_level", target_level, want.goal);
				if (sample_taken !== want.sampled)
					report_mismatch("sample_taken", sample_taken, want.sampled);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		cfg_night_thr = RST_NIGHT_THR;
		cfg_day_thr = RST_DAY_THR;
		cfg_night_lvl = RST_NIGHT_LEVEL;
		cfg_day_lvl = RST_DAY_LEVEL;
		cfg_default_lvl = RST_DEFAULT_LEVEL;
		cfg_ramp_period = RST_RAMP_PERIOD;
		cfg_sample_period = RST_SAMPLE_PERIOD;
		cfg_inverted = RST_POLARITY;
		level_now = cfg_default_lvl;
		level_goal = cfg_default_lvl;
		ramp_elapsed = '0;
		sample_elapsed = '0;
		duty_held = cfg_inverted ? FULL_SCALE - cfg_default_lvl : cfg_default_lvl;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_threshold_regions();
		test_falling_map();
		test_equal_thresholds();
		test_crossed_thresholds();
		test_polarity_and_unmapped_writes();
		test_disabled_hold();
		test_counter_saturation();
		test_output_backpressure();
		test_sender_pause();
		test_random_phases();

		wait_for_drain();
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
